@@ hw/rtl/ccs_pkg.sv @@
package ccs_pkg;

  // grid geometry
  localparam int MAX_WIDTH = 64;
  localparam int WIDTH_W   = 7;
  localparam int LIMIT_W   = 4;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  // result queue sizing
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;
  localparam int Q_ROOM  = Q_DEPTH - 2;

  // register reset values
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST   = WIDTH_W'(20);
  localparam logic [LIMIT_W-1:0] BIRTH_LIMIT_RST = LIMIT_W'(3);
  localparam logic [LIMIT_W-1:0] DEATH_LIMIT_RST = LIMIT_W'(4);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH   = 2'd0,
    CFG_BIRTH_LIMIT = 2'd1,
    CFG_DEATH_LIMIT = 2'd2
  } cfg_reg_t;

  typedef logic [MAX_WIDTH-1:0] row_t;

  // one result item
  typedef struct packed {
    row_t cells;
    logic frame_end;
  } ccs_item_t;

  // queue write strobes for the two results one row may cause
  typedef struct packed {
    logic first;
    logic second;
  } ccs_push_t;

endpackage

@@ hw/rtl/ccs_lane.sv @@
module ccs_lane (
  input  logic [2:0]                  up,
  input  logic [2:0]                  mid,
  input  logic [2:0]                  down,
  input  logic                        in_grid,
  input  logic [ccs_pkg::LIMIT_W-1:0] birth_limit,
  input  logic [ccs_pkg::LIMIT_W-1:0] death_limit,
  output logic                        cell_nxt
);
  import ccs_pkg::*;

  logic               self_cell;
  logic [COUNT_W-1:0] count;

  // marked neighbours of the centre cell
  assign self_cell = mid[1];
  assign count = COUNT_W'(up[0]) + COUNT_W'(up[1]) + COUNT_W'(up[2])
               + COUNT_W'(mid[0]) + COUNT_W'(mid[2])
               + COUNT_W'(down[0]) + COUNT_W'(down[1]) + COUNT_W'(down[2]);

  // death and birth rules, a cell outside the row gives zero
  always_comb begin
    cell_nxt = self_cell;
    if (self_cell && (count < death_limit)) cell_nxt = 1'b0;
    if (!self_cell && (count > birth_limit)) cell_nxt = 1'b1;
    if (!in_grid) cell_nxt = 1'b0;
  end

endmodule

@@ hw/rtl/ccs_row.sv @@
module ccs_row (
  input  logic [ccs_pkg::WIDTH_W-1:0] width_eff,
  input  logic [ccs_pkg::LIMIT_W-1:0] birth_limit,
  input  logic [ccs_pkg::LIMIT_W-1:0] death_limit,
  input  ccs_pkg::row_t               up_row,
  input  ccs_pkg::row_t               mid_row,
  input  ccs_pkg::row_t               down_row,
  output ccs_pkg::row_t               cells
);
  import ccs_pkg::*;

  // rows padded with an out-of-grid (marked) column on each side
  logic [MAX_WIDTH+1:0] up_x;
  logic [MAX_WIDTH+1:0] mid_x;
  logic [MAX_WIDTH+1:0] down_x;
  row_t                 in_grid;

  assign up_x[0]             = 1'b1;
  assign mid_x[0]            = 1'b1;
  assign down_x[0]           = 1'b1;
  assign up_x[MAX_WIDTH+1]   = 1'b1;
  assign mid_x[MAX_WIDTH+1]  = 1'b1;
  assign down_x[MAX_WIDTH+1] = 1'b1;

  // one lane per column, merged back into the row word
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_lane
    assign in_grid[i]  = (WIDTH_W'(i) < width_eff);
    assign up_x[i+1]   = in_grid[i] ? up_row[i]   : 1'b1;
    assign mid_x[i+1]  = in_grid[i] ? mid_row[i]  : 1'b1;
    assign down_x[i+1] = in_grid[i] ? down_row[i] : 1'b1;

    ccs_lane u_lane (
      .up          (up_x[i+2:i]),
      .mid         (mid_x[i+2:i]),
      .down        (down_x[i+2:i]),
      .in_grid     (in_grid[i]),
      .birth_limit (birth_limit),
      .death_limit (death_limit),
      .cell_nxt    (cells[i])
    );
  end

endmodule

@@ hw/rtl/ccs_outq.sv @@
module ccs_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  ccs_pkg::ccs_push_t  push,
  input  ccs_pkg::ccs_item_t  item_first,
  input  ccs_pkg::ccs_item_t  item_second,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output ccs_pkg::ccs_item_t  out_item
);
  import ccs_pkg::*;

  ccs_item_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign room      = (count_r <= Q_CNT_W'(Q_ROOM));

  // pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push.first) + Q_PTR_W'(push.second);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    count_nxt  = count_r + Q_CNT_W'(push.first) + Q_CNT_W'(push.second)
               - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // result storage, two writes in row order
  always_ff @(posedge clk) begin
    if (push.first) mem_r[wr_ptr_r] <= item_first;
    if (push.second) mem_r[wr_ptr_r + Q_PTR_W'(1)] <= item_second;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue fill count beyond depth");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second result written without first");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.first |-> count_r <= Q_CNT_W'(Q_ROOM))
    else $error("result written into queue without room");

  a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
    Q_PTR_W'(count_r) == Q_PTR_W'(wr_ptr_r - rd_ptr_r))
    else $error("queue pointers disagree with fill count");

endmodule

@@ hw/rtl/cellular_cave_smoothing_row.sv @@
// results: a row's result enters the result queue when the row below it is transferred;
//   a bottom row queues its own result (and the pending one first) when it arrives
// throughput: one row per cycle while the queue has room, set by the 64 parallel column
//   lanes; a bottom row with a pending row writes both results to a four-entry queue
// reset: synchronous active low; registers return to 20/3/4, held rows clear, queue empties
module cellular_cave_smoothing_row (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,   // [63:0] row_cells
  input  logic                          in_tlast,   // last_row
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata,  // [63:0] smoothed_cells
  output logic                          out_tlast,  // frame_end
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ccs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccs_pkg::CFG_DAT_W-1:0] cfg_data
);
  import ccs_pkg::*;

  logic [WIDTH_W-1:0] row_width_r;
  logic [LIMIT_W-1:0] birth_limit_r;
  logic [LIMIT_W-1:0] death_limit_r;
  logic [WIDTH_W-1:0] width_eff;

  row_t       row_above_r, row_above_nxt;
  row_t       row_pending_r, row_pending_nxt;
  logic       held_r, held_nxt;
  logic       in_fire;
  logic       room;
  row_t       mid_a, down_a;
  row_t       cells_a, cells_b;
  ccs_push_t  push;
  ccs_item_t  item_first, item_second, out_item;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= ROW_WIDTH_RST;
      birth_limit_r <= BIRTH_LIMIT_RST;
      death_limit_r <= DEATH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROW_WIDTH:   row_width_r   <= cfg_data;
        CFG_BIRTH_LIMIT: birth_limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_DEATH_LIMIT: death_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp width into 1..MAX_WIDTH
  always_comb begin
    priority if (row_width_r == '0) width_eff = WIDTH_W'(1);
    else if (row_width_r > WIDTH_W'(MAX_WIDTH)) width_eff = WIDTH_W'(MAX_WIDTH);
    else width_eff = row_width_r;
  end

  // input transfer needs room for two results
  assign in_tready = room;
  assign in_fire   = in_tvalid && in_tready;

  // first unit: pending row, or the lone bottom row of a single-row grid
  assign mid_a  = held_r ? row_pending_r : in_tdata;
  assign down_a = held_r ? in_tdata : '1;

  ccs_row u_row_a (
    .width_eff   (width_eff),
    .birth_limit (birth_limit_r),
    .death_limit (death_limit_r),
    .up_row      (row_above_r),
    .mid_row     (mid_a),
    .down_row    (down_a),
    .cells       (cells_a)
  );

  // second unit: bottom row flushed after the pending one
  ccs_row u_row_b (
    .width_eff   (width_eff),
    .birth_limit (birth_limit_r),
    .death_limit (death_limit_r),
    .up_row      (row_pending_r),
    .mid_row     (in_tdata),
    .down_row    ('1),
    .cells       (cells_b)
  );

  // results and row window update
  always_comb begin
    push.first             = in_fire && (held_r || in_tlast);
    push.second            = in_fire && held_r && in_tlast;
    item_first.cells       = cells_a;
    item_first.frame_end   = !held_r;
    item_second.cells      = cells_b;
    item_second.frame_end  = 1'b1;
    row_above_nxt          = row_above_r;
    row_pending_nxt        = row_pending_r;
    held_nxt               = held_r;
    if (in_fire) begin
      if (in_tlast) begin
        row_above_nxt   = '1;
        row_pending_nxt = '0;
        held_nxt        = 1'b0;
      end else begin
        if (held_r) row_above_nxt = row_pending_r;
        row_pending_nxt = in_tdata;
        held_nxt        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r   <= '1;
      row_pending_r <= '0;
      held_r        <= 1'b0;
    end else begin
      row_above_r   <= row_above_nxt;
      row_pending_r <= row_pending_nxt;
      held_r        <= held_nxt;
    end
  end

  ccs_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .item_first  (item_first),
    .item_second (item_second),
    .room        (room),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_item    (out_item)
  );

  assign out_tdata = out_item.cells;
  assign out_tlast = out_item.frame_end;

  a_bottom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (!held_r && row_above_r == '1))
    else $error("row window not cleared after bottom row");

  a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !held_r && !in_tlast) |-> !push.first)
    else $error("result written for a first row");

  a_pending_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && held_r) |=> out_tvalid)
    else $error("pending row not offered after the row below");

endmodule
